FILE: hdl/spin_ramp_brake_sequencer_top_defines.svh
// Assertion macros used by the spin sequencer checker.
`ifndef SPIN_RAMP_BRAKE_SEQUENCER_TOP_DEFINES_SVH
`define SPIN_RAMP_BRAKE_SEQUENCER_TOP_DEFINES_SVH

// Checked only while the block is out of reset.
`define SRBS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define SRBS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: hdl/srbs_pkg.sv
// Shared types, codes, microcode word layout and ease table for the spin sequencer.
package srbs_pkg;

  localparam int unsigned EASE_DEPTH = 256;
  localparam int unsigned IDX_W      = $clog2(EASE_DEPTH);
  localparam int unsigned CNT_W      = $clog2(IDX_W + 1);
  localparam int unsigned DIVD_W     = 16 + IDX_W;
  localparam int unsigned EASE_W     = 17;
  localparam int unsigned PC_W       = 6;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned IN_TDATA_W  = 64;
  localparam int unsigned OUT_TDATA_W = 72;
  localparam int unsigned OUT_PHASE_LSB = 32;
  localparam int unsigned OUT_DONE_BIT  = 35;
  localparam int unsigned OUT_ERR_LSB   = 36;

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_RAMP   = 3'd1;
  localparam logic [2:0] PH_CRUISE = 3'd2;
  localparam logic [2:0] PH_BRAKE  = 3'd3;
  localparam logic [2:0] PH_SETTLE = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_CRUISE_SPEED = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_TIME    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPIN_TOTAL   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BRAKE_LEAD   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE_TIME  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CRUISE_CUR   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BRAKE_CUR    = 3'd6;

  typedef enum logic [3:0] {
    CMD_SPEED       = 4'd0,
    CMD_MODE_SPEED  = 4'd1,
    CMD_MODE_POS    = 4'd2,
    CMD_GAIN_CRUISE = 4'd3,
    CMD_GAIN_BRAKE  = 4'd4,
    CMD_CUR_SPEED   = 4'd5,
    CMD_CUR_POS     = 4'd6,
    CMD_POS_TARGET  = 4'd7,
    CMD_NONE        = 4'd8
  } cmd_e;

  typedef enum logic [3:0] {
    OP_NOP, OP_ELAPSED, OP_START, OP_DIV_INIT, OP_DIV_STEP, OP_MUL, OP_SCALE,
    OP_CRUISE, OP_TRAVEL, OP_BRAKE, OP_SETTLE, OP_ERROR, OP_IDLE
  } op_e;

  typedef enum logic [3:0] {
    COND_NEVER, COND_ALWAYS, COND_MODE, COND_PH_RAMP, COND_PH_CRUISE,
    COND_PH_BRAKE, COND_PH_SETTLE, COND_RAMP_DONE, COND_DIV_MORE, COND_FIRE,
    COND_SETTLE_DONE
  } cond_e;

  typedef enum logic [2:0] {
    VS_ZERO, VS_CUR_SPEED, VS_SPEED, VS_CUR_POS, VS_TARGET
  } vsel_e;

  typedef struct packed {
    op_e             op;
    logic            emit;
    cmd_e            cmd;
    vsel_e           vsel;
    logic            done;
    logic            last;
    cond_e           cond;
    logic [PC_W-1:0] target;
    logic            fin;
  } uword_t;

  typedef struct packed {
    logic       mode;
    logic [2:0] phase;
    logic       ramp_done;
    logic       settle_done;
    logic       div_more;
    logic       fire;
    logic       out_free;
  } stat_t;

  typedef struct packed {
    logic take;
    logic go;
  } ctl_t;

  typedef logic [EASE_W-1:0] ease_rom_t [EASE_DEPTH];

  // Entry i is round(65536 * sin^2(pi*i/(2*depth))), sine from a Q30 Taylor series.
  function automatic ease_rom_t build_ease_rom();
    ease_rom_t   rom;
    logic [63:0] a;
    logic [63:0] a2;
    logic [63:0] term;
    logic [63:0] sum;
    for (int i = 0; i < EASE_DEPTH; i++) begin
      a    = (HALF_PI_Q30 * 64'(i)) / EASE_DEPTH;
      a2   = (a * a) >> 30;
      term = a;
      sum  = a;
      for (int k = 1; k <= 8; k++) begin
        term = ((term * a2) >> 30) / 64'((2 * k) * (2 * k + 1));
        if ((k & 1) == 1) begin
          sum = (sum >= term) ? sum - term : 64'd0;
        end else begin
          sum = sum + term;
        end
      end
      if (sum > (64'd1 << 30)) begin
        sum = 64'd1 << 30;
      end
      rom[i] = EASE_W'((sum * sum + (64'd1 << 43)) >> 44);
    end
    return rom;
  endfunction

  localparam ease_rom_t EASE_ROM = build_ease_rom();

endpackage

FILE: hdl/spin_ramp_brake_sequencer_top.sv
// Top level of the spin ramp and brake sequencer, a microcoded step machine.
// One input word is worked at a time; s_tready_o rises again the cycle after its last step.
// A ramp tick finds its ease index with a bit-serial index divider, and a step that emits a
// result word waits while the output register is stalled.
// Reset is asynchronous and active low: configuration returns to defaults and the phase to idle.
module spin_ramp_brake_sequencer_top import srbs_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   s_tvalid_i,
  output logic                   s_tready_o,
  // time_ms [31:0], encoder_pos [63:32]
  input  logic [IN_TDATA_W-1:0]  s_tdata_i,
  // mode [0]
  input  logic [0:0]             s_tuser_i,
  output logic                   m_tvalid_o,
  input  logic                   m_tready_i,
  // value [31:0], phase [34:32], spin_done [35], final_error [67:36], zero [71:68]
  output logic [OUT_TDATA_W-1:0] m_tdata_o,
  // command [3:0]
  output logic [3:0]             m_tuser_o,
  output logic                   m_tlast_o
);

  uword_t          uw;
  stat_t           stat;
  ctl_t            ctl;
  logic [PC_W-1:0] pc;
  logic            busy;
  cmd_e            out_cmd;
  logic [31:0]     out_value;
  logic [2:0]      out_phase;
  logic            out_done;
  logic [31:0]     out_err;

  srbs_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .uw_i       (uw),
    .stat_i     (stat),
    .ctl_o      (ctl),
    .pc_o       (pc),
    .busy_o     (busy)
  );

  srbs_ucode_rom u_rom (
    .pc_i (pc),
    .uw_o (uw)
  );

  srbs_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .ctl_i       (ctl),
    .uw_i        (uw),
    .mode_i      (s_tuser_i[0]),
    .time_i      (s_tdata_i[31:0]),
    .enc_i       (s_tdata_i[63:32]),
    .m_tready_i  (m_tready_i),
    .stat_o      (stat),
    .out_valid_o (m_tvalid_o),
    .out_cmd_o   (out_cmd),
    .out_value_o (out_value),
    .out_phase_o (out_phase),
    .out_done_o  (out_done),
    .out_err_o   (out_err),
    .out_last_o  (m_tlast_o)
  );

  assign cfg_ready_o = 1'b1;
  assign s_tready_o  = !busy;
  assign m_tuser_o   = out_cmd;
  assign m_tdata_o   = {4'd0, out_err, out_done, out_phase, out_value};

endmodule

FILE: hdl/srbs_ucode_rom.sv
// Microcode program store: one control word for each sequencer step.
module srbs_ucode_rom import srbs_pkg::*; (
  input  logic [PC_W-1:0] pc_i,
  output uword_t          uw_o
);

  localparam logic [PC_W-1:0] S_ENTRY       = PC_W'(0);
  localparam logic [PC_W-1:0] S_TRY_RAMP    = PC_W'(1);
  localparam logic [PC_W-1:0] S_TRY_CRUISE  = PC_W'(2);
  localparam logic [PC_W-1:0] S_TRY_BRAKE   = PC_W'(3);
  localparam logic [PC_W-1:0] S_TRY_SETTLE  = PC_W'(4);
  localparam logic [PC_W-1:0] S_GO_IDLE     = PC_W'(5);
  localparam logic [PC_W-1:0] S_START       = PC_W'(6);
  localparam logic [PC_W-1:0] S_ST_E0       = PC_W'(7);
  localparam logic [PC_W-1:0] S_ST_E1       = PC_W'(8);
  localparam logic [PC_W-1:0] S_ST_E2       = PC_W'(9);
  localparam logic [PC_W-1:0] S_ST_E3       = PC_W'(10);
  localparam logic [PC_W-1:0] S_ST_E4       = PC_W'(11);
  localparam logic [PC_W-1:0] S_RAMP        = PC_W'(12);
  localparam logic [PC_W-1:0] S_DIV_INIT    = PC_W'(13);
  localparam logic [PC_W-1:0] S_DIV         = PC_W'(14);
  localparam logic [PC_W-1:0] S_MUL         = PC_W'(15);
  localparam logic [PC_W-1:0] S_SCALE       = PC_W'(16);
  localparam logic [PC_W-1:0] S_RAMP_OUT    = PC_W'(17);
  localparam logic [PC_W-1:0] S_RAMP_END    = PC_W'(18);
  localparam logic [PC_W-1:0] S_CRUISE      = PC_W'(19);
  localparam logic [PC_W-1:0] S_FIRE_TEST   = PC_W'(20);
  localparam logic [PC_W-1:0] S_CRUISE_OUT  = PC_W'(21);
  localparam logic [PC_W-1:0] S_FIRE        = PC_W'(22);
  localparam logic [PC_W-1:0] S_BK_E0       = PC_W'(23);
  localparam logic [PC_W-1:0] S_BK_E1       = PC_W'(24);
  localparam logic [PC_W-1:0] S_BK_E2       = PC_W'(25);
  localparam logic [PC_W-1:0] S_BK_E3       = PC_W'(26);
  localparam logic [PC_W-1:0] S_BK_E4       = PC_W'(27);
  localparam logic [PC_W-1:0] S_BRAKE       = PC_W'(28);
  localparam logic [PC_W-1:0] S_SETTLE      = PC_W'(29);
  localparam logic [PC_W-1:0] S_SETTLE_WAIT = PC_W'(30);
  localparam logic [PC_W-1:0] S_SETTLE_END  = PC_W'(31);
  localparam logic [PC_W-1:0] S_DONE_OUT    = PC_W'(32);

  function automatic uword_t op_word(op_e op, cond_e cond, logic [PC_W-1:0] tgt,
                                     logic fin);
    uword_t w;
    w        = '0;
    w.op     = op;
    w.emit   = 1'b0;
    w.cmd    = CMD_NONE;
    w.vsel   = VS_ZERO;
    w.cond   = cond;
    w.target = tgt;
    w.fin    = fin;
    return w;
  endfunction

  function automatic uword_t emit_word(cmd_e cmd, vsel_e vs, logic done, logic last);
    uword_t w;
    w        = '0;
    w.op     = OP_NOP;
    w.emit   = 1'b1;
    w.cmd    = cmd;
    w.vsel   = vs;
    w.done   = done;
    w.last   = last;
    w.cond   = COND_NEVER;
    w.target = S_ENTRY;
    w.fin    = last;
    return w;
  endfunction

  always_comb begin
    unique case (pc_i)
      S_ENTRY:       uw_o = op_word(OP_ELAPSED, COND_MODE, S_START, 1'b0);
      S_TRY_RAMP:    uw_o = op_word(OP_NOP, COND_PH_RAMP, S_RAMP, 1'b0);
      S_TRY_CRUISE:  uw_o = op_word(OP_NOP, COND_PH_CRUISE, S_CRUISE, 1'b0);
      S_TRY_BRAKE:   uw_o = op_word(OP_NOP, COND_PH_BRAKE, S_BRAKE, 1'b0);
      S_TRY_SETTLE:  uw_o = op_word(OP_NOP, COND_PH_SETTLE, S_SETTLE, 1'b0);
      S_GO_IDLE:     uw_o = op_word(OP_IDLE, COND_NEVER, S_ENTRY, 1'b1);
      S_START:       uw_o = op_word(OP_START, COND_NEVER, S_ENTRY, 1'b0);
      S_ST_E0:       uw_o = emit_word(CMD_SPEED, VS_ZERO, 1'b0, 1'b0);
      S_ST_E1:       uw_o = emit_word(CMD_MODE_SPEED, VS_ZERO, 1'b0, 1'b0);
      S_ST_E2:       uw_o = emit_word(CMD_GAIN_CRUISE, VS_ZERO, 1'b0, 1'b0);
      S_ST_E3:       uw_o = emit_word(CMD_CUR_SPEED, VS_CUR_SPEED, 1'b0, 1'b0);
      S_ST_E4:       uw_o = emit_word(CMD_SPEED, VS_ZERO, 1'b0, 1'b1);
      S_RAMP:        uw_o = op_word(OP_NOP, COND_RAMP_DONE, S_RAMP_END, 1'b0);
      S_DIV_INIT:    uw_o = op_word(OP_DIV_INIT, COND_NEVER, S_ENTRY, 1'b0);
      S_DIV:         uw_o = op_word(OP_DIV_STEP, COND_DIV_MORE, S_DIV, 1'b0);
      S_MUL:         uw_o = op_word(OP_MUL, COND_NEVER, S_ENTRY, 1'b0);
      S_SCALE:       uw_o = op_word(OP_SCALE, COND_NEVER, S_ENTRY, 1'b0);
      S_RAMP_OUT:    uw_o = emit_word(CMD_SPEED, VS_SPEED, 1'b0, 1'b1);
      S_RAMP_END:    uw_o = op_word(OP_CRUISE, COND_ALWAYS, S_RAMP_OUT, 1'b0);
      S_CRUISE:      uw_o = op_word(OP_TRAVEL, COND_NEVER, S_ENTRY, 1'b0);
      S_FIRE_TEST:   uw_o = op_word(OP_NOP, COND_FIRE, S_FIRE, 1'b0);
      S_CRUISE_OUT:  uw_o = emit_word(CMD_SPEED, VS_SPEED, 1'b0, 1'b1);
      S_FIRE:        uw_o = op_word(OP_BRAKE, COND_NEVER, S_ENTRY, 1'b0);
      S_BK_E0:       uw_o = emit_word(CMD_SPEED, VS_SPEED, 1'b0, 1'b0);
      S_BK_E1:       uw_o = emit_word(CMD_GAIN_BRAKE, VS_ZERO, 1'b0, 1'b0);
      S_BK_E2:       uw_o = emit_word(CMD_MODE_POS, VS_ZERO, 1'b0, 1'b0);
      S_BK_E3:       uw_o = emit_word(CMD_CUR_POS, VS_CUR_POS, 1'b0, 1'b0);
      S_BK_E4:       uw_o = emit_word(CMD_POS_TARGET, VS_TARGET, 1'b0, 1'b1);
      S_BRAKE:       uw_o = op_word(OP_SETTLE, COND_NEVER, S_ENTRY, 1'b1);
      S_SETTLE:      uw_o = op_word(OP_NOP, COND_SETTLE_DONE, S_SETTLE_END, 1'b0);
      S_SETTLE_WAIT: uw_o = op_word(OP_NOP, COND_NEVER, S_ENTRY, 1'b1);
      S_SETTLE_END:  uw_o = op_word(OP_ERROR, COND_NEVER, S_ENTRY, 1'b0);
      S_DONE_OUT:    uw_o = emit_word(CMD_NONE, VS_ZERO, 1'b1, 1'b1);
      default:       uw_o = op_word(OP_NOP, COND_NEVER, S_ENTRY, 1'b1);
    endcase
  end

endmodule

FILE: hdl/srbs_sequencer.sv
// Step counter with conditional jumps that walks the microcode program for one word.
module srbs_sequencer import srbs_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_tvalid_i,
  input  uword_t          uw_i,
  input  stat_t           stat_i,
  output ctl_t            ctl_o,
  output logic [PC_W-1:0] pc_o,
  output logic            busy_o
);

  logic            busy_q;
  logic [PC_W-1:0] pc_q;
  logic            cond_true;

  always_comb begin
    unique case (uw_i.cond)
      COND_NEVER:       cond_true = 1'b0;
      COND_ALWAYS:      cond_true = 1'b1;
      COND_MODE:        cond_true = stat_i.mode;
      COND_PH_RAMP:     cond_true = (stat_i.phase == PH_RAMP);
      COND_PH_CRUISE:   cond_true = (stat_i.phase == PH_CRUISE);
      COND_PH_BRAKE:    cond_true = (stat_i.phase == PH_BRAKE);
      COND_PH_SETTLE:   cond_true = (stat_i.phase == PH_SETTLE);
      COND_RAMP_DONE:   cond_true = stat_i.ramp_done;
      COND_DIV_MORE:    cond_true = stat_i.div_more;
      COND_FIRE:        cond_true = stat_i.fire;
      COND_SETTLE_DONE: cond_true = stat_i.settle_done;
      default:          cond_true = 1'b0;
    endcase
  end

  assign ctl_o.take = s_tvalid_i && !busy_q;
  assign ctl_o.go   = busy_q && !(uw_i.emit && !stat_i.out_free);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pc_q   <= '0;
    end else if (ctl_o.take) begin
      busy_q <= 1'b1;
      pc_q   <= '0;
    end else if (ctl_o.go) begin
      if (uw_i.fin) begin
        busy_q <= 1'b0;
      end else if (cond_true) begin
        pc_q <= uw_i.target;
      end else begin
        pc_q <= pc_q + PC_W'(1);
      end
    end
  end

  assign pc_o   = pc_q;
  assign busy_o = busy_q;

endmodule

FILE: hdl/srbs_datapath.sv
// Spin state, configuration registers, index divider, speed multiplier and output register.
module srbs_datapath import srbs_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  ctl_t                  ctl_i,
  input  uword_t                uw_i,
  input  logic                  mode_i,
  input  logic [31:0]           time_i,
  input  logic [31:0]           enc_i,
  input  logic                  m_tready_i,
  output stat_t                 stat_o,
  output logic                  out_valid_o,
  output cmd_e                  out_cmd_o,
  output logic [31:0]           out_value_o,
  output logic [2:0]            out_phase_o,
  output logic                  out_done_o,
  output logic [31:0]           out_err_o,
  output logic                  out_last_o
);

  logic [15:0] cruise_q;
  logic [15:0] ramp_q;
  logic [30:0] total_q;
  logic [30:0] lead_q;
  logic [15:0] settle_q;
  logic [11:0] ccur_q;
  logic [11:0] bcur_q;

  logic        mode_q;
  logic [31:0] time_q;
  logic [31:0] enc_q;

  logic [2:0]  phase_q;
  logic [31:0] start_q;
  logic [31:0] origin_q;
  logic [31:0] target_q;
  logic [15:0] speed_q;

  logic [31:0]        elapsed_q;
  logic [15:0]        rem_q;
  logic [IDX_W-1:0]   low_q;
  logic [IDX_W-1:0]   quot_q;
  logic [CNT_W-1:0]   dcnt_q;
  logic [32:0]        prod_q;
  logic signed [32:0] travel_q;
  logic [31:0]        err_q;

  logic               out_valid_q;
  cmd_e               out_cmd_q;
  logic [31:0]        out_value_q;
  logic [2:0]         out_phase_q;
  logic               out_done_q;
  logic [31:0]        out_err_q;
  logic               out_last_q;

  logic [32:0]        target_sum;
  logic [32:0]        err_diff;
  logic signed [32:0] travel_d;
  logic signed [32:0] limit;
  logic [DIVD_W-1:0]  divd;
  logic [16:0]        div_try;
  logic               div_ge;
  logic [16:0]        div_sub;
  logic [EASE_W-1:0]  ease;
  logic [33:0]        rnd;
  logic [15:0]        speed_sat;
  logic [31:0]        emit_value;
  logic               out_free;

  function automatic logic [31:0] sat33(logic [32:0] v);
    if (v[32] != v[31]) begin
      return v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    return v[31:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cruise_q <= 16'd800;
      ramp_q   <= 16'd2000;
      total_q  <= 31'd36000;
      lead_q   <= 31'd1000;
      settle_q <= 16'd1000;
      ccur_q   <= 12'd1000;
      bcur_q   <= 12'd1500;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_CRUISE_SPEED: cruise_q <= cfg_data_i[15:0];
        REG_RAMP_TIME:    ramp_q   <= cfg_data_i[15:0];
        REG_SPIN_TOTAL:   total_q  <= cfg_data_i[30:0];
        REG_BRAKE_LEAD:   lead_q   <= cfg_data_i[30:0];
        REG_SETTLE_TIME:  settle_q <= cfg_data_i[15:0];
        REG_CRUISE_CUR:   ccur_q   <= cfg_data_i[11:0];
        REG_BRAKE_CUR:    bcur_q   <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.take) begin
      mode_q <= mode_i;
      time_q <= time_i;
      enc_q  <= enc_i;
    end
  end

  assign target_sum = {enc_q[31], enc_q} + {2'b00, total_q};
  assign err_diff   = {enc_q[31], enc_q} - {target_q[31], target_q};
  assign travel_d   = $signed({enc_q[31], enc_q}) - $signed({origin_q[31], origin_q});
  assign limit      = $signed({2'b00, total_q}) - $signed({2'b00, lead_q});

  assign divd    = DIVD_W'(elapsed_q[15:0]) * DIVD_W'(EASE_DEPTH);
  assign div_try = {rem_q, low_q[IDX_W-1]};
  assign div_ge  = div_try >= {1'b0, ramp_q};
  assign div_sub = div_try - {1'b0, ramp_q};

  assign ease      = EASE_ROM[quot_q];
  assign rnd       = {1'b0, prod_q} + 34'd32768;
  assign speed_sat = (|rnd[33:32]) ? 16'hFFFF : rnd[31:16];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      start_q  <= '0;
      origin_q <= '0;
      target_q <= '0;
      speed_q  <= '0;
    end else if (ctl_i.go) begin
      case (uw_i.op)
        OP_START: begin
          origin_q <= enc_q;
          target_q <= sat33(target_sum);
          speed_q  <= '0;
          start_q  <= time_q;
          phase_q  <= PH_RAMP;
        end
        OP_SCALE: speed_q <= speed_sat;
        OP_CRUISE: begin
          speed_q <= cruise_q;
          start_q <= time_q;
          phase_q <= PH_CRUISE;
        end
        OP_BRAKE: begin
          start_q <= time_q;
          phase_q <= PH_BRAKE;
        end
        OP_SETTLE: begin
          start_q <= time_q;
          phase_q <= PH_SETTLE;
        end
        OP_ERROR: phase_q <= PH_IDLE;
        OP_IDLE:  phase_q <= PH_IDLE;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.go) begin
      case (uw_i.op)
        OP_ELAPSED: elapsed_q <= time_q - start_q;
        OP_DIV_INIT: begin
          rem_q  <= divd[DIVD_W-1:IDX_W];
          low_q  <= divd[IDX_W-1:0];
          quot_q <= '0;
          dcnt_q <= CNT_W'(IDX_W);
        end
        OP_DIV_STEP: begin
          rem_q  <= div_ge ? div_sub[15:0] : div_try[15:0];
          low_q  <= low_q << 1;
          quot_q <= {quot_q[IDX_W-2:0], div_ge};
          dcnt_q <= dcnt_q - CNT_W'(1);
        end
        OP_MUL:    prod_q   <= 33'(cruise_q) * 33'(ease);
        OP_TRAVEL: travel_q <= travel_d;
        OP_ERROR:  err_q    <= sat33(err_diff);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (uw_i.vsel)
      VS_CUR_SPEED: emit_value = {20'd0, ccur_q};
      VS_SPEED:     emit_value = {16'd0, speed_q};
      VS_CUR_POS:   emit_value = {20'd0, bcur_q};
      VS_TARGET:    emit_value = target_q;
      default:      emit_value = '0;
    endcase
  end

  assign out_free = !out_valid_q || m_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.go && uw_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.go && uw_i.emit) begin
      out_cmd_q   <= uw_i.cmd;
      out_value_q <= emit_value;
      out_phase_q <= phase_q;
      out_done_q  <= uw_i.done;
      out_err_q   <= uw_i.done ? err_q : 32'd0;
      out_last_q  <= uw_i.last;
    end
  end

  assign stat_o.mode        = mode_q;
  assign stat_o.phase       = phase_q;
  assign stat_o.ramp_done   = elapsed_q >= {16'd0, ramp_q};
  assign stat_o.settle_done = elapsed_q >= {16'd0, settle_q};
  assign stat_o.div_more    = dcnt_q > CNT_W'(1);
  assign stat_o.fire        = travel_q >= limit;
  assign stat_o.out_free    = out_free;

  assign out_valid_o = out_valid_q;
  assign out_cmd_o   = out_cmd_q;
  assign out_value_o = out_value_q;
  assign out_phase_o = out_phase_q;
  assign out_done_o  = out_done_q;
  assign out_err_o   = out_err_q;
  assign out_last_o  = out_last_q;

endmodule

FILE: hdl/srbs_checker.sv
// Port-level checker for the spin sequencer, bound to the top level.
`include "spin_ramp_brake_sequencer_top_defines.svh"

module srbs_checker import srbs_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_tvalid_i,
  input logic                   s_tready_i,
  input logic                   m_tvalid_i,
  input logic                   m_tready_i,
  input logic [OUT_TDATA_W-1:0] m_tdata_i,
  input logic [3:0]             m_tuser_i,
  input logic                   m_tlast_i
);

  `SRBS_ASSERT(a_out_hold, m_tvalid_i && !m_tready_i |=> m_tvalid_i && $stable(m_tdata_i) && $stable(m_tuser_i) && $stable(m_tlast_i), "Stalled output word changed.")
  `SRBS_ASSERT(a_done_is_final, m_tvalid_i && m_tdata_i[OUT_DONE_BIT] |-> m_tuser_i == CMD_NONE && m_tlast_i && m_tdata_i[OUT_DONE_BIT-1:OUT_PHASE_LSB] == PH_IDLE, "Done word is malformed.")
  `SRBS_ASSERT(a_err_zero, m_tvalid_i && !m_tdata_i[OUT_DONE_BIT] |-> m_tdata_i[OUT_TDATA_W-1:OUT_ERR_LSB] == '0, "Error field set without done.")
  `SRBS_ASSERT(a_busy_after_take, s_tvalid_i && s_tready_i |=> !s_tready_i, "Input taken while a word is in work.")
  `SRBS_ASSERT_RST(a_reset_quiet, !rst_ni |-> !m_tvalid_i && s_tready_i, "Ports not quiet in reset.")

endmodule

bind spin_ramp_brake_sequencer_top srbs_checker u_srbs_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_tvalid_i),
  .s_tready_i (s_tready_o),
  .m_tvalid_i (m_tvalid_o),
  .m_tready_i (m_tready_i),
  .m_tdata_i  (m_tdata_o),
  .m_tuser_i  (m_tuser_o),
  .m_tlast_i  (m_tlast_o)
);
